FILE: rtl/plb_pkg.sv
// Shared types and constants for the page buffer LRU lookup unit.
// No dependencies.
package plb_pkg;

  localparam int PAGE_W      = 32;
  localparam int SLOT_W      = 4;
  localparam int TS_W        = 30;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [TS_W-1:0]   ts_t;

  // Write command from the sequencer into the slot store
  typedef struct packed {
    logic tag_we;     // install new tag, mark slot valid
    logic dirty_we;
    logic dirty_val;
    logic ts_we;      // store new timestamp, mark it live
    logic wrap;       // clock wrapped: every timestamp reads zero
  } wr_cmd_t;

  // Running flags of the slot scan
  typedef struct packed {
    logic hit;
    logic free;
  } scan_flags_t;

endpackage

FILE: rtl/plb_store.sv
// Slot store: tag and timestamp memories plus valid/dirty/live flags.
// Depends on plb_pkg.
module plb_store
  import plb_pkg::*;
#(
  parameter  int ENTRIES = 16,
  localparam int IDX_W   = $clog2(ENTRIES)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  logic [IDX_W-1:0]   rd_addr_i,
  output page_t              rd_tag_o,
  output ts_t                rd_ts_o,
  output logic               rd_valid_o,
  input  wr_cmd_t            wr_cmd_i,
  input  logic [IDX_W-1:0]   wr_idx_i,
  input  page_t              wr_tag_i,
  input  ts_t                wr_ts_i,
  output logic [ENTRIES-1:0] dirty_o
);

  page_t              tag_mem [ENTRIES];
  ts_t                ts_mem  [ENTRIES];
  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] dirty_q;
  logic [ENTRIES-1:0] live_q;
  page_t              rd_tag_q;
  ts_t                rd_ts_q;
  logic               rd_live_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_cmd_i.tag_we) tag_mem[wr_idx_i] <= wr_tag_i;
    if (wr_cmd_i.ts_we)  ts_mem[wr_idx_i]  <= wr_ts_i;
    if (rd_en_i) begin
      rd_tag_q   <= tag_mem[rd_addr_i];
      rd_ts_q    <= ts_mem[rd_addr_i];
      rd_live_q  <= live_q[rd_addr_i];
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      live_q  <= '0;
    end else begin
      if (wr_cmd_i.tag_we)   valid_q[wr_idx_i] <= 1'b1;
      if (wr_cmd_i.dirty_we) dirty_q[wr_idx_i] <= wr_cmd_i.dirty_val;
      if (wr_cmd_i.wrap) begin
        live_q <= '0;
      end else if (wr_cmd_i.ts_we) begin
        live_q[wr_idx_i] <= 1'b1;
      end
    end
  end

  // a timestamp not written since the last wrap reads as zero
  assign rd_ts_o    = rd_live_q ? rd_ts_q : '0;
  assign rd_tag_o   = rd_tag_q;
  assign rd_valid_o = rd_valid_q;
  assign dirty_o    = dirty_q;

endmodule

FILE: rtl/plb_scan.sv
// Shared compare unit: one slot per cycle against the request tag and the running minimum.
// Depends on plb_pkg.
module plb_scan
  import plb_pkg::*;
#(
  parameter  int ENTRIES = 16,
  localparam int IDX_W   = $clog2(ENTRIES)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             rd_vld_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  input  page_t            rd_tag_i,
  input  ts_t              rd_ts_i,
  input  logic             rd_valid_i,
  input  page_t            page_i,
  output scan_flags_t      flags_o,
  output logic [IDX_W-1:0] hit_idx_o,
  output logic [IDX_W-1:0] free_idx_o,
  output logic [IDX_W-1:0] best_idx_o,
  output page_t            best_tag_o
);

  scan_flags_t      flags_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [IDX_W-1:0] free_idx_q;
  logic [IDX_W-1:0] best_idx_q;
  ts_t              best_ts_q;
  page_t            best_tag_q;
  logic             is_hit;
  logic             is_free;
  logic             take_best;

  always_comb begin
    is_hit    = rd_valid_i && (rd_tag_i == page_i);
    is_free   = !rd_valid_i;
    // slot zero seeds the minimum; strict less keeps the lowest index on ties
    take_best = (rd_idx_i == '0) || (rd_ts_i < best_ts_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (start_i) begin
      flags_q <= '0;
    end else if (rd_vld_i) begin
      if (is_hit)  flags_q.hit  <= 1'b1;
      if (is_free) flags_q.free <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_i && !start_i) begin
      if (is_hit && !flags_q.hit)   hit_idx_q  <= rd_idx_i;
      if (is_free && !flags_q.free) free_idx_q <= rd_idx_i;
      if (take_best) begin
        best_idx_q <= rd_idx_i;
        best_ts_q  <= rd_ts_i;
        best_tag_q <= rd_tag_i;
      end
    end
  end

  assign flags_o    = flags_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign best_idx_o = best_idx_q;
  assign best_tag_o = best_tag_q;

endmodule

FILE: rtl/page_buffer_lru_lookup_unit.sv
// Top level of the page buffer LRU lookup unit: sequencer, access clock, result register.
// Depends on plb_pkg, plb_store and plb_scan.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid/s_axis_tready    tdata: page_no; tuser: is_write
//   m_axis    out  m_axis_tvalid/m_axis_tready    tdata: slot, hit, writeback_needed,
//                                                        evicted_page
//
// Each item runs through accept, a scan of every slot via the single read port of the
// slot store, and a commit.
// Reset frees every slot and clears the access clock; no clearing pass is needed.
// The next item is taken while a result waits on m_axis; a stalled result holds the
// following item in its commit cycle until the output register frees up.
module page_buffer_lru_lookup_unit
  import plb_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] page_no
  input  logic                   s_axis_tuser,  // [0] is_write
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [3:0] slot, [4] hit,
                                                // [5] writeback_needed,
                                                // [37:6] evicted_page, [39:38] zero
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  page_t              page_q;
  logic               wr_q;
  ts_t                clock_q, clock_d;
  logic               out_vld_q;
  logic [SLOT_W-1:0]  res_slot_q;
  logic               res_hit_q;
  logic               res_wb_q;
  page_t              res_evicted_q;

  logic               accept;
  logic               rd_issue;
  logic               scan_last;
  logic               commit_go;
  logic [IDX_W-1:0]   vic_idx;
  logic               wb;
  logic [TS_W:0]      clk_next;
  logic               wrap;
  wr_cmd_t            wr_cmd;

  page_t              rd_tag;
  ts_t                rd_ts;
  logic               rd_valid;
  logic [ENTRIES-1:0] dirty;
  scan_flags_t        flags;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;
  logic [IDX_W-1:0]   best_idx;
  page_t              best_tag;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rd_issue      = (state_q == ST_SCAN) && (cnt_q != CNT_W'(ENTRIES));
  assign scan_last     = (state_q == ST_SCAN) && (cnt_q == CNT_W'(ENTRIES));
  assign commit_go     = (state_q == ST_COMMIT) && (!out_vld_q || m_axis_tready);

  always_comb begin
    // with no free slot every slot is valid, so the LRU victim is the only dirty case
    vic_idx  = flags.hit ? hit_idx : (flags.free ? free_idx : best_idx);
    wb       = !flags.hit && !flags.free && dirty[best_idx];
    clk_next = {1'b0, clock_q} + (TS_W + 1)'(1);
    wrap     = clk_next[TS_W];

    wr_cmd.tag_we    = commit_go && !flags.hit;
    wr_cmd.dirty_we  = commit_go && (!flags.hit || wr_q);
    wr_cmd.dirty_val = wr_q;
    wr_cmd.ts_we     = commit_go && !wrap;
    wr_cmd.wrap      = commit_go && wrap;

    clock_d = clock_q;
    if (commit_go) clock_d = wrap ? '0 : clk_next[TS_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        if (rd_issue) cnt_d = cnt_q + CNT_W'(1);
        if (scan_last) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      clock_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_issue;
      clock_q  <= clock_d;
      if (commit_go) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q[IDX_W-1:0];
    if (accept) begin
      page_q <= s_axis_tdata[PAGE_W-1:0];
      wr_q   <= s_axis_tuser;
    end
    if (commit_go) begin
      res_slot_q    <= SLOT_W'(vic_idx);
      res_hit_q     <= flags.hit;
      res_wb_q      <= wb;
      res_evicted_q <= wb ? best_tag : '0;
    end
  end

  plb_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_issue),
    .rd_addr_i  (cnt_q[IDX_W-1:0]),
    .rd_tag_o   (rd_tag),
    .rd_ts_o    (rd_ts),
    .rd_valid_o (rd_valid),
    .wr_cmd_i   (wr_cmd),
    .wr_idx_i   (vic_idx),
    .wr_tag_i   (page_q),
    .wr_ts_i    (clk_next[TS_W-1:0]),
    .dirty_o    (dirty)
  );

  plb_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .rd_vld_i   (rd_vld_q),
    .rd_idx_i   (rd_idx_q),
    .rd_tag_i   (rd_tag),
    .rd_ts_i    (rd_ts),
    .rd_valid_i (rd_valid),
    .page_i     (page_q),
    .flags_o    (flags),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx),
    .best_idx_o (best_idx),
    .best_tag_o (best_tag)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, res_evicted_q, res_wb_q, res_hit_q, res_slot_q};

  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_hit_q |-> !res_wb_q)
    else $error("hit reported together with write-back");

  a_evicted_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !res_wb_q |-> res_evicted_q == '0)
    else $error("evicted page nonzero without write-back");

  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_SCAN && cnt_q == '0)
    else $error("accepted item did not start a scan");

  a_commit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_COMMIT && out_vld_q && !m_axis_tready |=> state_q == ST_COMMIT)
    else $error("commit overran a stalled result");

endmodule

FILE: dv/tb_page_buffer_lru_lookup_unit.sv
// Testbench for page_buffer_lru_lookup_unit: random and directed page requests, checked
// against an in-bench LRU slot table predictor. Depends on plb_pkg and the RTL only.
`timescale 1ns / 100ps

module tb_page_buffer_lru_lookup_unit;
  import plb_pkg::*;

  localparam int ENTRIES        = 16;
  localparam int IDLE_PCT       = 37;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 3 * (ENTRIES + 3);
  localparam int POOL_MAX       = 32;

  typedef struct packed {
    logic [1:0]        pad;
    page_t             evicted_page;
    logic              writeback_needed;
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } lookup_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] page_no
  logic                   s_axis_tuser = 1'b0; // [0] is_write
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;       // [3:0] slot, [4] hit, [5] writeback_needed,
                                              // [37:6] evicted_page, [39:38] zero

  // Predictor copy of the slot table
  page_t buf_tag      [ENTRIES];
  logic  buf_valid    [ENTRIES];
  logic  buf_dirty    [ENTRIES];
  ts_t   buf_last_use [ENTRIES];
  ts_t   access_clock;

  lookup_result_t pending_results[$];
  page_t          page_pool[POOL_MAX];

  bit no_idle = 1'b0;
  int mismatches = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int hits_seen = 0;
  int writebacks_seen = 0;
  int stall_cycles = 0;

  page_buffer_lru_lookup_unit #(.ENTRIES(ENTRIES)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_table();
    for (int i = 0; i < ENTRIES; i++) begin
      buf_tag[i]      = '0;
      buf_valid[i]    = 1'b0;
      buf_dirty[i]    = 1'b0;
      buf_last_use[i] = '0;
    end
    access_clock = '0;
  endfunction

  // Lowest valid match hits; else first free slot, else oldest timestamp (lowest on ties).
  function automatic lookup_result_t predict_lookup(page_t page, logic wr);
    lookup_result_t r;
    int             idx;
    int             oldest;
    logic [TS_W:0]  next_clock;
    r = '0;
    idx = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (idx < 0 && buf_valid[i] && buf_tag[i] == page) idx = i;
    if (idx >= 0) begin
      r.hit = 1'b1;
    end else begin
      oldest = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (idx < 0) begin
          if (!buf_valid[i]) idx = i;
          else if (buf_last_use[i] < buf_last_use[oldest]) oldest = i;
        end
      end
      if (idx < 0) idx = oldest;
      if (buf_valid[idx] && buf_dirty[idx]) begin
        r.writeback_needed = 1'b1;
        r.evicted_page     = buf_tag[idx];
      end
      buf_tag[idx]   = page;
      buf_valid[idx] = 1'b1;
      buf_dirty[idx] = 1'b0;
    end
    if (wr) buf_dirty[idx] = 1'b1;
    next_clock = {1'b0, access_clock} + (TS_W + 1)'(1);
    if (next_clock[TS_W]) begin
      // clock wrap: every timestamp, the fresh one too, restarts at zero
      access_clock = '0;
      for (int i = 0; i < ENTRIES; i++) buf_last_use[i] = '0;
    end else begin
      access_clock      = next_clock[TS_W-1:0];
      buf_last_use[idx] = next_clock[TS_W-1:0];
    end
    r.slot = idx[SLOT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] exp_v,
                                 input logic [63:0] got_v);
    $display("[%0t] mismatch on %s: expected %0h, got %0h (result %0d)",
             $realtime, field, exp_v, got_v, results_seen);
    mismatches++;
  endtask

  task automatic check_result(input lookup_result_t got);
    lookup_result_t exp;
    if (pending_results.size() == 0) begin
      $display("[%0t] result item with nothing expected: %0h", $realtime, got);
      mismatches++;
    end else begin
      exp = pending_results.pop_front();
      if (got.slot !== exp.slot) report_mismatch("slot", 64'(exp.slot), 64'(got.slot));
      if (got.hit !== exp.hit) report_mismatch("hit", 64'(exp.hit), 64'(got.hit));
      if (got.writeback_needed !== exp.writeback_needed)
        report_mismatch("writeback_needed", 64'(exp.writeback_needed),
                        64'(got.writeback_needed));
      if (got.evicted_page !== exp.evicted_page)
        report_mismatch("evicted_page", 64'(exp.evicted_page), 64'(got.evicted_page));
      if (got.pad !== exp.pad) report_mismatch("padding", 64'(exp.pad), 64'(got.pad));
      hits_seen       += int'(exp.hit);
      writebacks_seen += int'(exp.writeback_needed);
    end
    results_seen++;
  endtask

  // Result side: check, random backpressure, watchdog on accepted items
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no item moved for %0d cycles", $realtime, stall_cycles);
      $display("FAILURE");
      $finish;
    end
    m_axis_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Leaves tvalid high after acceptance so back-to-back items need one assignment per edge
  task automatic send_request(input page_t page, input logic wr);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= page;
    s_axis_tuser  <= wr;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_lookup(page, wr));
    requests_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Extreme pages, hits on clean and dirty slots, full table, clean and dirty victims
  task automatic test_directed();
    send_request(32'h0000_0000, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b1);
    send_request(32'hFFFF_FFFF, 1'b0);
    send_request(32'h0000_0000, 1'b1);
    for (int i = 0; i < ENTRIES - 2; i++)
      send_request(32'h8000_1000 + i, i[0]);
    send_request(32'h5555_AAAA, 1'b0);  // evicts the dirty all-ones page
    send_request(32'hAAAA_5555, 1'b1);  // evicts the dirty page zero
    send_request(32'h0000_0001, 1'b0);  // clean victim
    send_request(32'hFFFF_FFFF, 1'b0);  // re-fetch of an evicted page, dirty victim
    send_request(32'h8000_1003, 1'b0);  // hit on a dirty slot
    wait_drained();
  endtask

  // Requests drawn mostly from a working set, so hits, LRU thrash and write-backs mix
  task automatic test_working_set(input int count, input int set_size, input int fresh_pct);
    page_t page;
    int    pick;
    for (int i = 0; i < set_size; i++) page_pool[i] = $urandom();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(set_size - 1);
      if ($urandom_range(99) < fresh_pct) begin
        page = $urandom();
        page_pool[pick] = page;  // working set drifts over time
      end else begin
        page = page_pool[pick];
      end
      send_request(page, 1'($urandom_range(1)));
    end
    wait_drained();
  endtask

  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    test_working_set(count, ENTRIES + 2, 10);
    no_idle = 1'b0;
  endtask

  task automatic test_random_pages(input int count);
    for (int n = 0; n < count; n++) send_request($urandom(), 1'($urandom_range(1)));
    wait_drained();
  endtask

  initial begin
    clear_table();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_working_set(400, 8, 5);
    test_working_set(400, ENTRIES + 4, 10);
    test_working_set(400, ENTRIES + 1, 3);
    test_back_to_back(300);
    test_random_pages(100);

    $display("Ran %0d page requests, %0d results: %0d hits, %0d misses, %0d write-backs.",
             requests_sent, results_seen, hits_seen, results_seen - hits_seen,
             writebacks_seen);
    $display("Detected %0d mismatches.", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/plb_pkg.sv
rtl/plb_store.sv
rtl/plb_scan.sv
rtl/page_buffer_lru_lookup_unit.sv
dv/tb_page_buffer_lru_lookup_unit.sv
